### src/ttfb_pkg.sv
// Shared types and constants of the tagged tile fill buffer.
// Field widths, operation and status codes, lookup result struct.
// No dependencies.
package ttfb_pkg;

   // Fixed field widths of the channels
   localparam int MODE_W     = 3;
   localparam int TAG_IN_W   = 16;
   localparam int ADDR_W     = 64;
   localparam int SIZE_W     = 7;
   localparam int WORD_W     = 64;
   localparam int STATUS_W   = 3;
   localparam int SLOT_W     = 3;
   localparam int BNUM_W     = 3;

   // One block is eight bytes
   localparam int BLOCK_BYTES = 8;
   localparam int BYTE_SHIFT  = 3;
   localparam int BIDX_W      = SIZE_W - BYTE_SHIFT;

   // Widest entry index the table supports (64 entries)
   localparam int LOOKUP_IDX_W = 6;

   typedef enum logic [MODE_W-1:0] {
      MODE_ALLOC = 3'd0,
      MODE_FILL  = 3'd1,
      MODE_QUERY = 3'd2,
      MODE_READ  = 3'd3,
      MODE_CLEAR = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUP       = 3'd2,
      ST_MISSING   = 3'd3,
      ST_RANGE     = 3'd4,
      ST_REFILL    = 3'd5,
      ST_NOT_READY = 3'd6
   } status_type;

   typedef struct packed {
      logic                    hit;
      logic [LOOKUP_IDX_W-1:0] hit_idx;
      logic                    free_ok;
      logic [LOOKUP_IDX_W-1:0] free_idx;
   } lookup_type;

endpackage

### src/ttfb_chan_if.sv
// Valid/ready channel interfaces of the tagged tile fill buffer.
// Depends on ttfb_pkg for the field widths.
interface ttfb_req_if import ttfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [TAG_IN_W-1:0] tag;
   logic [ADDR_W-1:0]   address;
   logic [SIZE_W-1:0]   tile_size;
   logic [WORD_W-1:0]   fill_word;

   modport source (output valid, mode, tag, address, tile_size, fill_word, input ready);
   modport sink   (input valid, mode, tag, address, tile_size, fill_word, output ready);
endinterface

interface ttfb_rsp_if import ttfb_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                ready_res;
   logic [SLOT_W-1:0]   slot;
   logic [BNUM_W-1:0]   block_number;
   logic [WORD_W-1:0]   read_word;
   logic                last;

   modport source (output valid, status, ready_res, slot, block_number, read_word, last,
                   input ready);
   modport sink   (input valid, status, ready_res, slot, block_number, read_word, last,
                   output ready);
endinterface

### src/ttfb_lookup.sv
// Tag match and free-entry search over the entry table.
// Depends on ttfb_pkg (lookup_type).
module ttfb_lookup import ttfb_pkg::*; #(
   parameter int ENTRIES = 8,
   parameter int TAG_W   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [ENTRIES-1:0] valid,
   input  logic [TAG_W-1:0]   tags [ENTRIES],
   input  logic [TAG_W-1:0]   key,
   output lookup_type         result
);

   logic [ENTRIES-1:0] match_vec;

   // Compare every valid entry against the key
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid[i] && (tags[i] == key);
      end
   end

   // Lowest matching entry and lowest free entry win
   always_comb begin
      result = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            result.hit     = 1'b1;
            result.hit_idx = LOOKUP_IDX_W'(i);
         end
         if (!valid[i]) begin
            result.free_ok  = 1'b1;
            result.free_idx = LOOKUP_IDX_W'(i);
         end
      end
   end

   // Allocation refuses duplicates, so a tag lives in at most one entry
   a_unique_tag: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("tag matches more than one entry");

endmodule

### src/tagged_tile_fill_buffer_unit.sv
// Top level of the tagged tile fill buffer: input register, entry table,
// block store and result register. Depends on ttfb_pkg, ttfb_chan_if, ttfb_lookup.
//
//   channel  | dir | transfer when          | payload
//   req_if   | in  | valid & ready at edge  | mode, tag, address, tile_size, fill_word
//   rsp_if   | out | valid & ready at edge  | status, ready_res, slot, block_number,
//            |     |                        | read_word, last
//
// One item per cycle unless the result channel stalls or a tile read holds its item; a
// result is registered after the input register. A ready tile gives BLOCKS blocks, one
// per cycle unless stalled, via the single store read port. Unused modes make no result.
// Synchronous reset clears the entry flags; the block store is not cleared.
// A stalled result holds in its register; the input register holds and req ready drops.
module tagged_tile_fill_buffer_unit import ttfb_pkg::*; #(
   parameter int ENTRIES  = 8,
   parameter int BLOCKS   = 8,
   parameter int TAG_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ttfb_req_if.sink   req_if,
   ttfb_rsp_if.source rsp_if
);

   localparam int EW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int BW        = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CW        = $clog2(BLOCKS + 1);
   localparam int TAG_W     = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
   localparam int MEM_DEPTH = 2 ** (EW + BW);
   localparam logic [5:0]    BLOCKS_V   = 6'(BLOCKS);
   localparam logic [BW-1:0] LAST_BLOCK = BW'(BLOCKS - 1);

   // Input register
   logic                in_vld_ff;
   logic [MODE_W-1:0]   in_mode_ff;
   logic [TAG_W-1:0]    in_tag_ff;
   logic [ADDR_W-1:0]   in_addr_ff;
   logic [SIZE_W-1:0]   in_size_ff;
   logic [WORD_W-1:0]   in_word_ff;

   // Entry table
   logic [ENTRIES-1:0]  entry_valid_ff;
   logic [ENTRIES-1:0]  entry_ready_ff;
   logic [TAG_W-1:0]    entry_tag_ff  [ENTRIES];
   logic [ADDR_W-1:0]   entry_base_ff [ENTRIES];
   logic [SIZE_W-1:0]   entry_size_ff [ENTRIES];
   logic [BLOCKS-1:0]   fill_map_ff   [ENTRIES];
   logic [CW-1:0]       fill_cnt_ff   [ENTRIES];

   // Block store
   logic [WORD_W-1:0]   block_mem [MEM_DEPTH];
   logic [WORD_W-1:0]   mem_rd_ff;

   // Read sweep counter
   logic [BW-1:0]       blk_ff;

   // Result register
   logic                rsp_vld_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_rdy_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [BNUM_W-1:0]   rsp_bnum_ff;
   logic                rsp_last_ff;
   logic                word_hit_ff;

   lookup_type          lk;
   logic [EW-1:0]       hit_e;
   logic [EW-1:0]       free_e;
   logic [ADDR_W-1:0]   base_e;
   logic [SIZE_W-1:0]   size_e;
   logic [BLOCKS-1:0]   map_e;
   logic [CW-1:0]       cnt_e;
   logic                rdy_e;
   logic [ADDR_W-1:0]   offset;
   logic [BIDX_W-1:0]   idx;
   logic                in_range;
   logic                idx_ok;
   logic [BLOCKS-1:0]   map_shift;
   logic [BLOCKS-1:0]   blk_shift;
   logic                bit_set;
   logic [BLOCKS-1:0]   new_map;
   logic [CW-1:0]       new_cnt;
   logic [SIZE_W:0]     size_round;
   logic [5:0]          expect_cnt;
   logic                rdy_new;
   logic [BW-1:0]       fill_blk;

   logic                has_rsp;
   logic                done;
   logic                reading;
   logic                do_alloc;
   logic                do_fill;
   logic                do_clear;
   status_type          res_status;
   logic                res_rdy;
   logic [EW-1:0]       res_slot;
   logic [BNUM_W-1:0]   res_bnum;
   logic                res_last;
   logic                res_word_hit;

   logic                out_free;
   logic                advance;
   logic                consume;

   ttfb_lookup #(
      .ENTRIES (ENTRIES),
      .TAG_W   (TAG_W)
   ) u_lookup (
      .clock  (clock),
      .reset  (reset),
      .valid  (entry_valid_ff),
      .tags   (entry_tag_ff),
      .key    (in_tag_ff),
      .result (lk)
   );

   // Fetch the matched entry and work out the fill block
   always_comb begin
      hit_e      = lk.hit_idx[EW-1:0];
      free_e     = lk.free_idx[EW-1:0];
      base_e     = entry_base_ff[hit_e];
      size_e     = entry_size_ff[hit_e];
      map_e      = fill_map_ff[hit_e];
      cnt_e      = fill_cnt_ff[hit_e];
      rdy_e      = entry_ready_ff[hit_e];
      offset     = in_addr_ff - base_e;
      in_range   = offset < ADDR_W'(size_e);
      idx        = offset[SIZE_W-1:BYTE_SHIFT];
      idx_ok     = {2'b00, idx} < BLOCKS_V;
      fill_blk   = BW'(idx);
      map_shift  = map_e >> idx;
      bit_set    = map_shift[0];
      blk_shift  = map_e >> blk_ff;
      new_map    = map_e | (BLOCKS'(1) << idx);
      new_cnt    = cnt_e + CW'(1);
      size_round = {1'b0, size_e} + (SIZE_W + 1)'(BLOCK_BYTES - 1);
      expect_cnt = 6'(size_round[SIZE_W:BYTE_SHIFT]);
      rdy_new    = rdy_e || (6'(new_cnt) >= expect_cnt);
   end

   // Decide the result and the table update of the held item
   always_comb begin
      has_rsp      = 1'b1;
      done         = 1'b1;
      reading      = 1'b0;
      do_alloc     = 1'b0;
      do_fill      = 1'b0;
      do_clear     = 1'b0;
      res_status   = ST_OK;
      res_rdy      = 1'b0;
      res_slot     = '0;
      res_bnum     = '0;
      res_last     = 1'b1;
      res_word_hit = 1'b0;
      unique case (in_mode_ff)
         MODE_ALLOC: begin
            priority if (lk.hit) begin
               res_status = ST_DUP;
               res_rdy    = rdy_e;
               res_slot   = hit_e;
            end else if (!lk.free_ok) begin
               res_status = ST_FULL;
            end else begin
               res_slot = free_e;
               do_alloc = 1'b1;
            end
         end
         MODE_FILL: begin
            priority if (!lk.hit) begin
               res_status = ST_MISSING;
            end else if (!in_range || !idx_ok) begin
               res_status = ST_RANGE;
               res_rdy    = rdy_e;
               res_slot   = hit_e;
            end else if (bit_set) begin
               res_status = ST_REFILL;
               res_rdy    = rdy_e;
               res_slot   = hit_e;
               res_bnum   = BNUM_W'(idx);
            end else begin
               res_rdy  = rdy_new;
               res_slot = hit_e;
               res_bnum = BNUM_W'(idx);
               do_fill  = 1'b1;
            end
         end
         MODE_QUERY: begin
            if (!lk.hit) begin
               res_status = ST_MISSING;
            end else begin
               res_rdy  = rdy_e;
               res_slot = hit_e;
            end
         end
         MODE_READ: begin
            priority if (!lk.hit) begin
               res_status = ST_MISSING;
            end else if (!rdy_e) begin
               res_status = ST_NOT_READY;
               res_slot   = hit_e;
            end else begin
               reading      = 1'b1;
               res_rdy      = 1'b1;
               res_slot     = hit_e;
               res_bnum     = BNUM_W'(blk_ff);
               res_last     = (blk_ff == LAST_BLOCK);
               done         = (blk_ff == LAST_BLOCK);
               res_word_hit = blk_shift[0];
            end
         end
         MODE_CLEAR: begin
            if (!lk.hit) begin
               res_status = ST_MISSING;
            end else begin
               res_slot = hit_e;
               do_clear = 1'b1;
            end
         end
         default: begin
            has_rsp = 1'b0;
         end
      endcase
   end

   // Handshake: advance when the result register can take the result, or when the item has no result
   assign out_free      = !rsp_vld_ff || rsp_if.ready;
   assign advance       = in_vld_ff && (!has_rsp || out_free);
   assign consume       = advance && done;
   assign req_if.ready  = !in_vld_ff || consume;

   // Hold the input item until its last result is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_vld_ff <= req_if.valid;
      end
      if (req_if.ready && req_if.valid) begin
         in_mode_ff <= req_if.mode;
         in_tag_ff  <= req_if.tag[TAG_W-1:0];
         in_addr_ff <= req_if.address;
         in_size_ff <= req_if.tile_size;
         in_word_ff <= req_if.fill_word;
      end
   end

   // Advance the block counter of a tile read
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
      end else if (advance && reading) begin
         blk_ff <= (blk_ff == LAST_BLOCK) ? '0 : blk_ff + BW'(1);
      end
   end

   // Update the entry table
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         entry_ready_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            fill_map_ff[i] <= '0;
            fill_cnt_ff[i] <= '0;
         end
      end else if (advance) begin
         if (do_alloc) begin
            entry_valid_ff[free_e] <= 1'b1;
            entry_ready_ff[free_e] <= 1'b0;
            entry_tag_ff[free_e]   <= in_tag_ff;
            entry_base_ff[free_e]  <= in_addr_ff;
            entry_size_ff[free_e]  <= in_size_ff;
            fill_map_ff[free_e]    <= '0;
            fill_cnt_ff[free_e]    <= '0;
         end
         if (do_fill) begin
            fill_map_ff[hit_e]    <= new_map;
            fill_cnt_ff[hit_e]    <= new_cnt;
            entry_ready_ff[hit_e] <= rdy_new;
         end
         if (do_clear) begin
            entry_valid_ff[hit_e] <= 1'b0;
            entry_ready_ff[hit_e] <= 1'b0;
            fill_map_ff[hit_e]    <= '0;
            fill_cnt_ff[hit_e]    <= '0;
         end
      end
   end

   // Write one block on a successful fill
   always_ff @(posedge clock) begin
      if (advance && do_fill) begin
         block_mem[{hit_e, fill_blk}] <= in_word_ff;
      end
   end

   // Read the swept block straight into the result register
   always_ff @(posedge clock) begin
      if (advance && has_rsp) begin
         mem_rd_ff <= block_mem[{hit_e, blk_ff}];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && has_rsp) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (advance && has_rsp) begin
         rsp_status_ff <= res_status;
         rsp_rdy_ff    <= res_rdy;
         rsp_slot_ff   <= SLOT_W'(res_slot);
         rsp_bnum_ff   <= res_bnum;
         rsp_last_ff   <= res_last;
         word_hit_ff   <= res_word_hit;
      end
   end

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.ready_res    = rsp_rdy_ff;
   assign rsp_if.slot         = rsp_slot_ff;
   assign rsp_if.block_number = rsp_bnum_ff;
   assign rsp_if.last         = rsp_last_ff;
   assign rsp_if.read_word    = word_hit_ff ? mem_rd_ff : '0;

   // Only the blocks of a ready tile come out without last
   a_burst_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.last |-> rsp_if.status == ST_OK && rsp_if.ready_res)
      else $error("non-final result outside a tile read");

   // A tile read keeps streaming once a block is taken
   a_burst_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.last |=> rsp_if.valid)
      else $error("tile read stream broke off");

   // Only a live entry can be ready
   a_ready_live: assert property (@(posedge clock) disable iff (reset)
      (entry_ready_ff & ~entry_valid_ff) == '0)
      else $error("ready flag on a free entry");

   // The sweep counter only moves while a read item is held
   a_sweep_held: assert property (@(posedge clock) disable iff (reset)
      blk_ff != '0 |-> in_vld_ff && in_mode_ff == MODE_READ)
      else $error("block counter running without a read");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for tagged_tile_fill_buffer_unit: a driver and a monitor on the two
// valid/ready channels and a tag-table predictor that is updated on every input transfer.
// Depends on ttfb_pkg, ttfb_chan_if and the unit itself.
module tb_top;
   import ttfb_pkg::*;

   localparam int ENTRIES  = 8;
   localparam int BLOCKS   = 8;
   localparam int TAG_BITS = 16;
   localparam bit [TAG_IN_W-1:0] TAG_MASK = TAG_IN_W'((64'd1 << TAG_BITS) - 1);

   // Mode codes the unit drops without a result
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_OPS  = 170;
   localparam int TAIL_OPS    = 25;
   localparam int HOLD_AFTER  = 60;
   localparam int HOLD_CYCLES = 120;
   localparam int DRAIN_WAIT  = 24;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [MODE_W-1:0] mode;
      bit [TAG_IN_W-1:0] tag;
      bit [ADDR_W-1:0]   address;
      bit [SIZE_W-1:0]   tile_size;
      bit [WORD_W-1:0]   fill_word;
   } tile_op_type;

   typedef struct {
      status_type        status;
      bit                ready_res;
      bit [SLOT_W-1:0]   slot;
      bit [BNUM_W-1:0]   block_number;
      bit [WORD_W-1:0]   read_word;
      bit                last;
   } tile_result_type;

   logic clock;
   logic reset;

   ttfb_req_if req_bus ();
   ttfb_rsp_if rsp_bus ();

   tagged_tile_fill_buffer_unit #(
      .ENTRIES  (ENTRIES),
      .BLOCKS   (BLOCKS),
      .TAG_BITS (TAG_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   // Predicted copy of the tag table and block store
   bit              tile_live     [ENTRIES];
   bit [TAG_IN_W-1:0] tile_tag    [ENTRIES];
   bit [ADDR_W-1:0] tile_base     [ENTRIES];
   bit [SIZE_W-1:0] tile_size     [ENTRIES];
   bit [BLOCKS-1:0] tile_map      [ENTRIES];
   bit              tile_complete [ENTRIES];
   bit [WORD_W-1:0] tile_data     [ENTRIES][BLOCKS];

   tile_op_type      tile_ops_pending [$];
   tile_result_type  tile_results_due [$];
   bit [TAG_IN_W-1:0] parked_tags  [$];

   int ops_total;
   int table_ops_planned;
   int items_taken;
   int results_checked;
   int fills_stored;
   int full_reads;
   int mismatches;
   int cycle_count;
   int send_gap;
   int stall_gap;
   int hold_left;
   bit hold_started;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- reporting
   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH result %0d: %s", $time, results_checked, what);
   endtask

   task automatic check_field(input string field, input logic [63:0] seen,
                              input logic [63:0] want);
      if (seen !== want)
         flag_mismatch($sformatf("%s got %0h expected %0h", field, seen, want));
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic void post_result(input status_type st, input bit rdy, input int slot,
                                       input int blk, input bit [WORD_W-1:0] word,
                                       input bit last);
      tile_result_type r;
      r.status       = st;
      r.ready_res    = rdy;
      r.slot         = SLOT_W'(slot);
      r.block_number = BNUM_W'(blk);
      r.read_word    = word;
      r.last         = last;
      tile_results_due.insert(tile_results_due.size(), r);
   endfunction

   function automatic void wipe_tile(input int e);
      tile_live[e]     = 1'b0;
      tile_tag[e]      = '0;
      tile_base[e]     = '0;
      tile_size[e]     = '0;
      tile_map[e]      = '0;
      tile_complete[e] = 1'b0;
      for (int b = 0; b < BLOCKS; b++)
         tile_data[e][b] = '0;
   endfunction

   function automatic void apply_tile_op(input tile_op_type op);
      int                hit;
      int                free_slot;
      int                blk;
      int                need;
      bit [TAG_IN_W-1:0] key;
      bit [ADDR_W-1:0]   off;
      key       = op.tag & TAG_MASK;
      hit       = -1;
      free_slot = -1;
      for (int e = 0; e < ENTRIES; e++) begin
         if (tile_live[e] && tile_tag[e] == key && hit < 0)
            hit = e;
         if (!tile_live[e] && free_slot < 0)
            free_slot = e;
      end

      // Allocate checks the tag before fullness
      if (op.mode == MODE_ALLOC) begin
         if (hit >= 0) begin
            post_result(ST_DUP, tile_complete[hit], hit, 0, '0, 1'b1);
         end else if (free_slot < 0) begin
            post_result(ST_FULL, 1'b0, 0, 0, '0, 1'b1);
         end else begin
            wipe_tile(free_slot);
            tile_live[free_slot] = 1'b1;
            tile_tag[free_slot]  = key;
            tile_base[free_slot] = op.address;
            tile_size[free_slot] = op.tile_size;
            post_result(ST_OK, 1'b0, free_slot, 0, '0, 1'b1);
         end
         return;
      end
      if (op.mode > MODE_CLEAR)
         return;
      if (hit < 0) begin
         post_result(ST_MISSING, 1'b0, 0, 0, '0, 1'b1);
         return;
      end

      case (op.mode)
         MODE_FILL: begin
            off = op.address - tile_base[hit];
            if (off >= ADDR_W'(tile_size[hit]) || (off >> BYTE_SHIFT) >= BLOCKS) begin
               post_result(ST_RANGE, tile_complete[hit], hit, 0, '0, 1'b1);
            end else begin
               blk = int'(off >> BYTE_SHIFT);
               if (tile_map[hit][blk]) begin
                  post_result(ST_REFILL, tile_complete[hit], hit, blk, '0, 1'b1);
               end else begin
                  tile_data[hit][blk] = op.fill_word;
                  tile_map[hit][blk]  = 1'b1;
                  fills_stored++;
                  // Readiness only moves on a stored block
                  need = (int'(tile_size[hit]) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                  if ($countones(tile_map[hit]) >= need)
                     tile_complete[hit] = 1'b1;
                  post_result(ST_OK, tile_complete[hit], hit, blk, '0, 1'b1);
               end
            end
         end
         MODE_QUERY: post_result(ST_OK, tile_complete[hit], hit, 0, '0, 1'b1);
         MODE_READ: begin
            if (!tile_complete[hit]) begin
               post_result(ST_NOT_READY, 1'b0, hit, 0, '0, 1'b1);
            end else begin
               full_reads++;
               for (int b = 0; b < BLOCKS; b++)
                  post_result(ST_OK, 1'b1, hit, b, tile_map[hit][b] ? tile_data[hit][b] : '0,
                              b == BLOCKS - 1);
            end
         end
         default: begin
            wipe_tile(hit);
            post_result(ST_OK, 1'b0, hit, 0, '0, 1'b1);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_op(input logic [MODE_W-1:0] mode, input bit [15:0] tag,
                                    input bit [63:0] address, input bit [6:0] size,
                                    input bit [63:0] word);
      tile_op_type op;
      op.mode      = mode;
      op.tag       = tag;
      op.address   = address;
      op.tile_size = size;
      op.fill_word = word;
      tile_ops_pending.insert(tile_ops_pending.size(), op);
      if (mode <= MODE_CLEAR)
         table_ops_planned++;
   endfunction

   // One tile's life: allocate, fill in random order with disturbances, query, read, then free or park the tag
   function automatic void plan_tile();
      bit [15:0] tag;
      bit [63:0] base;
      bit [63:0] addr;
      bit [6:0]  size;
      int        n;
      int        lim;
      int        pick;
      int        tmp;
      int        order [BLOCKS];
      if (parked_tags.size() != 0 && $urandom_range(0, 7) == 0) begin
         pick = $urandom_range(0, parked_tags.size() - 1);
         tag  = parked_tags[pick];
         parked_tags.delete(pick);
      end else begin
         tag = 16'($urandom);
      end
      case ($urandom_range(0, 9))
         0:       base = ~64'h0 - 64'($urandom_range(0, 40));
         1:       base = rand64();
         default: base = rand64() & ~64'h7;
      endcase
      pick = $urandom_range(0, 19);
      if (pick == 0)
         size = '0;
      else if (pick == 1)
         size = 7'($urandom_range(65, 127));
      else if (pick < 6)
         size = 7'd64;
      else
         size = 7'($urandom_range(1, 64));
      queue_op(MODE_ALLOC, tag, base, size, rand64());

      n = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
      if (n > BLOCKS)
         n = BLOCKS;
      for (int i = 0; i < n; i++)
         order[i] = i;
      for (int i = n - 1; i > 0; i--) begin
         pick     = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[pick];
         order[pick] = tmp;
      end
      // Now and then hold back one block so the tile never completes
      if (n > 1 && $urandom_range(0, 9) == 0)
         n--;
      if (size == 0)
         queue_op(MODE_FILL, tag, base, 7'($urandom), rand64());
      if (size > 7'd64)
         queue_op(MODE_FILL, tag, base + 64 + 64'($urandom_range(0, int'(size) - 65)),
                  7'($urandom), rand64());

      for (int i = 0; i < n; i++) begin
         lim = int'(size) - 1 - order[i] * BLOCK_BYTES;
         if (lim > BLOCK_BYTES - 1)
            lim = BLOCK_BYTES - 1;
         addr = base + 64'(order[i] * BLOCK_BYTES) + 64'($urandom_range(0, lim));
         queue_op(MODE_FILL, tag, addr, 7'($urandom), rand64());
         case ($urandom_range(0, 15))
            0: queue_op(MODE_FILL, tag, addr, 7'($urandom), rand64());
            1: queue_op(MODE_FILL, tag, base + 64'(size) + 64'($urandom_range(0, 200)),
                        7'($urandom), rand64());
            2: queue_op(MODE_FILL, tag, base - 1 - 64'($urandom_range(0, 200)),
                        7'($urandom), rand64());
            3: queue_op(MODE_QUERY, tag, rand64(), 7'($urandom), rand64());
            4: queue_op(MODE_READ, tag, rand64(), 7'($urandom), rand64());
            5: queue_op(MODE_FILL, 16'($urandom), addr, 7'($urandom), rand64());
            6: queue_op(MODE_CLEAR, 16'($urandom), rand64(), 7'($urandom), rand64());
            7: queue_op(MODE_SPARE_LO + MODE_W'($urandom_range(0, 2)), tag, rand64(),
                        7'($urandom), rand64());
            default: ;
         endcase
      end
      queue_op(MODE_QUERY, tag, rand64(), 7'($urandom), rand64());
      queue_op(MODE_READ, tag, rand64(), 7'($urandom), rand64());
      if ($urandom_range(0, 4) == 0)
         parked_tags.insert(parked_tags.size(), tag);
      else
         queue_op(MODE_CLEAR, tag, rand64(), 7'($urandom), rand64());
      if (parked_tags.size() > 3)
         queue_op(MODE_CLEAR, parked_tags.pop_front(), rand64(), 7'($urandom), rand64());
   endfunction

   function automatic void plan_directed();
      bit [63:0] top_base;
      top_base = 64'hFFFF_FFFF_FFFF_FFF8;
      // Unknown tags on an empty table
      queue_op(MODE_QUERY, 16'h0000, 64'h0, 7'h0, 64'h0);
      queue_op(MODE_READ, 16'h1234, rand64(), 7'h7F, rand64());
      // Two-block tile at the top of the address space
      queue_op(MODE_ALLOC, 16'hFFFF, top_base, 7'd9, ~64'h0);
      queue_op(MODE_FILL, 16'hFFFF, top_base + 7, 7'h7F, ~64'h0);
      queue_op(MODE_READ, 16'hFFFF, 64'h0, 7'h0, 64'h0);
      queue_op(MODE_FILL, 16'hFFFF, top_base + 3, 7'h0, rand64());
      queue_op(MODE_FILL, 16'hFFFF, top_base - 1, 7'h0, rand64());
      // Address zero wraps to the second block and completes the tile
      queue_op(MODE_FILL, 16'hFFFF, 64'h0, 7'h0, 64'h0123_4567_89AB_CDEF);
      queue_op(MODE_READ, 16'hFFFF, 64'h0, 7'h0, 64'h0);
      queue_op(MODE_ALLOC, 16'hFFFF, rand64(), 7'd64, rand64());
      // Zero-size and oversized tiles
      queue_op(MODE_ALLOC, 16'h0000, 64'h0, 7'd0, 64'h0);
      queue_op(MODE_FILL, 16'h0000, 64'h0, 7'd0, 64'h0);
      queue_op(MODE_ALLOC, 16'h0001, 64'h8000_0000_0000_0000, 7'h7F, 64'h0);
      queue_op(MODE_FILL, 16'h0001, 64'h8000_0000_0000_0040, 7'h0, rand64());
      queue_op(MODE_CLEAR, 16'h4321, rand64(), 7'h0, rand64());
      // Fill the table, then overflow it
      for (int t = 2; t < ENTRIES - 1; t++)
         queue_op(MODE_ALLOC, 16'(t), rand64(), 7'd64, rand64());
      queue_op(MODE_ALLOC, 16'(ENTRIES - 1), rand64(), 7'd64, rand64());
      queue_op(MODE_SPARE_HI, 16'hFFFF, ~64'h0, 7'h7F, ~64'h0);
      // Free every entry
      queue_op(MODE_CLEAR, 16'hFFFF, 64'h0, 7'h0, 64'h0);
      for (int t = 0; t < ENTRIES - 1; t++)
         queue_op(MODE_CLEAR, 16'(t), rand64(), 7'($urandom), rand64());
   endfunction

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin : op_driver
      tile_op_type seen_op;
      tile_op_type next_op;
      if (!reset) begin
         // Predict on each accepted transfer
         if (req_bus.valid && req_bus.ready) begin
            seen_op.mode      = req_bus.mode;
            seen_op.tag       = req_bus.tag;
            seen_op.address   = req_bus.address;
            seen_op.tile_size = req_bus.tile_size;
            seen_op.fill_word = req_bus.fill_word;
            apply_tile_op(seen_op);
            items_taken <= items_taken + 1;
         end
         // Advance to the next item, or idle for a burst
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               req_bus.valid <= 1'b0;
               send_gap--;
            end else if (tile_ops_pending.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (tile_ops_pending.size() >= TAIL_OPS && hold_left == 0 &&
                         $urandom_range(0, 9) == 0) begin
               req_bus.valid <= 1'b0;
               send_gap = $urandom_range(0, 12);
            end else begin
               next_op = tile_ops_pending.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.mode      <= next_op.mode;
               req_bus.tag       <= next_op.tag;
               req_bus.address   <= next_op.address;
               req_bus.tile_size <= next_op.tile_size;
               req_bus.fill_word <= next_op.fill_word;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin : result_monitor
      tile_result_type want;
      if (!reset) begin
         // Check each result transfer against the oldest prediction
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (tile_results_due.size() == 0) begin
               flag_mismatch($sformatf("unexpected result status %0d slot %0d block %0d",
                                       rsp_bus.status, rsp_bus.slot, rsp_bus.block_number));
            end else begin
               want = tile_results_due.pop_front();
               check_field("status", 64'(rsp_bus.status), 64'(want.status));
               check_field("ready_res", 64'(rsp_bus.ready_res), 64'(want.ready_res));
               check_field("slot", 64'(rsp_bus.slot), 64'(want.slot));
               check_field("block_number", 64'(rsp_bus.block_number),
                           64'(want.block_number));
               check_field("read_word", rsp_bus.read_word, want.read_word);
               check_field("last", 64'(rsp_bus.last), 64'(want.last));
            end
            results_checked++;
         end
         // Stall the result channel in bursts, or hold it off for the long stretch
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_gap--;
         end else if (tile_ops_pending.size() >= TAIL_OPS && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_gap = $urandom_range(0, 12);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off, once, so the unit backs up into its input
   always @(posedge clock) begin : rsp_hold_timer
      if (!reset) begin
         if (!hold_started && items_taken >= HOLD_AFTER) begin
            hold_left    <= HOLD_CYCLES;
            hold_started <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // Run limit
   always @(posedge clock) begin : run_limit
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tagged_tile_fill_buffer_unit verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.mode      = '0;
      req_bus.tag       = '0;
      req_bus.address   = '0;
      req_bus.tile_size = '0;
      req_bus.fill_word = '0;
      rsp_bus.ready     = 1'b0;

      plan_directed();
      while (table_ops_planned < RANDOM_OPS)
         plan_tile();
      ops_total = tile_ops_pending.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for every item to be taken and every result to arrive
      while (items_taken != ops_total || tile_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tile_results_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", tile_results_due.size()));

      $display("Run covered %0d input transfers (%0d table operations), %0d results checked.",
               ops_total, table_ops_planned, results_checked);
      $display("Blocks stored: %0d, complete tiles read out: %0d, mismatches: %0d.",
               fills_stored, full_reads, mismatches);
      if (mismatches == 0)
         $display("tagged_tile_fill_buffer_unit verification clean");
      else
         $display("tagged_tile_fill_buffer_unit verification failed");
      $finish;
   end

endmodule
